/* design/rraf_pkg.sv */
// ----------------------------------------------------------------------------
// rraf_pkg
// Shared types, constants and helper functions of the rounded rectangle
// antialiased fill core.
// ----------------------------------------------------------------------------
package rraf_pkg;

    localparam int COORD_W    = 13;
    localparam int DIM_W      = 13;
    localparam int LOCAL_W    = 12;
    localparam int PIX_W      = 32;
    localparam int SCR_W      = 14;
    localparam int COV_W      = 3;
    localparam int RAD2_W     = 13;
    localparam int DIM2_W     = 14;
    localparam int SQ_W       = 26;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;

    localparam int MAX_SCREEN_DIM_DEFAULT = 4096;

    localparam logic [COV_W-1:0] COV_FULL     = 3'd4;
    localparam logic [CH_W-1:0]  ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RECT_LEFT,
        CFG_RECT_TOP,
        CFG_RECT_WIDTH,
        CFG_RECT_HEIGHT,
        CFG_CORNER_RADIUS,
        CFG_FILL_COLOR,
        CFG_SCREEN_WIDTH,
        CFG_SCREEN_HEIGHT
    } cfg_index_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic [DIM2_W-1:0]         w2;
        logic [DIM2_W-1:0]         h2;
        logic [RAD2_W-1:0]         r2;
        logic [SQ_W-1:0]           r2sq;
        logic [PIX_W-1:0]          color;
        logic [SCR_W-1:0]          sw_lim;
        logic [SCR_W-1:0]          sh_lim;
    } cfg_t;

    typedef struct packed {
        logic                    valid;
        logic                    on;
        logic signed [SCR_W-1:0] sx;
        logic signed [SCR_W-1:0] sy;
        logic [COV_W-1:0]        cov;
        logic [PIX_W-1:0]        dst;
    } cov_stage_t;

    function automatic logic [CH_W-1:0] alpha_of_cov(logic [COV_W-1:0] cov);
        logic [CH_W-1:0] a;
        case (cov)
            3'd1:    a = 8'd63;
            3'd2:    a = 8'd127;
            3'd3:    a = 8'd191;
            default: a = 8'd0;
        endcase
        return a;
    endfunction

    // Exact floor(x / 255) for any x up to 255 * 255, the largest blend sum.
    function automatic logic [CH_W-1:0] div255(logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

endpackage

/* design/rounded_rect_aa_fill_core.sv */
// ----------------------------------------------------------------------------
// rounded_rect_aa_fill_core
// Antialiased rounded rectangle fill with alpha blend, one pixel per clock.
// ----------------------------------------------------------------------------
// The core takes one pixel transaction in every clock cycle and never stalls:
// busy stays low. Each transaction gives exactly one result, shown on the
// result ports for one cycle with done high, after it passes through three
// register stages: the input register, the coverage stage with its four
// corner-distance squarers, and the blend stage with its result register.
// The receiver cannot hold results off, so it must take each one in the
// cycle it appears.
// Configuration writes take effect for transactions started after the
// cycle of the write.
module rounded_rect_aa_fill_core
    import rraf_pkg::*;
#(
    parameter int MAX_SCREEN_DIM = MAX_SCREEN_DIM_DEFAULT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [LOCAL_W-1:0]      local_col,
    input  logic [LOCAL_W-1:0]      local_row,
    input  logic [PIX_W-1:0]        dst_pixel,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    output logic                    done,
    output logic                    write_enable,
    output logic signed [SCR_W-1:0] screen_x,
    output logic signed [SCR_W-1:0] screen_y,
    output logic [PIX_W-1:0]        new_pixel,
    output logic [COV_W-1:0]        coverage
);

    cfg_t       cfg;
    cov_stage_t stage;

    logic               in_valid_reg;
    logic [LOCAL_W-1:0] col_reg;
    logic [LOCAL_W-1:0] row_reg;
    logic [PIX_W-1:0]   dst_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg <= local_col;
        row_reg <= local_row;
        dst_reg <= dst_pixel;
    end

    rraf_config #(
        .MAX_SCREEN_DIM (MAX_SCREEN_DIM)
    ) u_config (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rraf_coverage u_coverage (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (in_valid_reg),
        .col      (col_reg),
        .row      (row_reg),
        .dst      (dst_reg),
        .stage    (stage)
    );

    rraf_blend u_blend (
        .clk          (clk),
        .rst_n        (rst_n),
        .stage        (stage),
        .color        (cfg.color),
        .done         (done),
        .write_enable (write_enable),
        .screen_x     (screen_x),
        .screen_y     (screen_y),
        .new_pixel    (new_pixel),
        .coverage     (coverage)
    );

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##3 done)
        else $error("A transaction did not produce a result three cycles later.");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 3))
        else $error("A result appeared without a matching transaction.");

    a_write_needs_coverage: assert property (@(posedge clk) disable iff (!rst_n)
        write_enable |-> (done && (coverage != '0)))
        else $error("A write was issued without coverage or outside a result.");

    a_idle_pixel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !write_enable) |-> (new_pixel == '0))
        else $error("A result without a write carries a nonzero pixel.");

endmodule

/* design/rraf_config.sv */
// ----------------------------------------------------------------------------
// rraf_config
// Configuration registers and the values derived from them: the clamped
// corner radius in half-pixel units, its square and the clipped screen size.
// ----------------------------------------------------------------------------
module rraf_config
    import rraf_pkg::*;
#(
    parameter int MAX_SCREEN_DIM = MAX_SCREEN_DIM_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    localparam logic [SCR_W-1:0] MaxDim = SCR_W'(MAX_SCREEN_DIM);

    logic signed [COORD_W-1:0] left_reg;
    logic signed [COORD_W-1:0] top_reg;
    logic [DIM_W-1:0]          width_reg;
    logic [DIM_W-1:0]          height_reg;
    logic [DIM_W-1:0]          radius_reg;
    logic [PIX_W-1:0]          color_reg;
    logic [DIM_W-1:0]          sw_reg;
    logic [DIM_W-1:0]          sh_reg;

    logic [RAD2_W-1:0] r2_reg;
    logic [RAD2_W-1:0] r2_next;
    logic [SQ_W-1:0]   r2sq_reg;
    logic [SQ_W-1:0]   r2sq_next;
    logic [SCR_W-1:0]  sw_lim_reg;
    logic [SCR_W-1:0]  sw_lim_next;
    logic [SCR_W-1:0]  sh_lim_reg;
    logic [SCR_W-1:0]  sh_lim_next;

    logic [DIM_W-1:0] rad_w;
    logic [DIM_W-1:0] rad_h;

    always_comb
    begin
        rad_w = radius_reg;
        if ({radius_reg, 1'b0} > {1'b0, width_reg})
        begin
            rad_w = width_reg >> 1;
        end
        rad_h = rad_w;
        if ({rad_w, 1'b0} > {1'b0, height_reg})
        begin
            rad_h = height_reg >> 1;
        end
        r2_next     = {rad_h[RAD2_W-2:0], 1'b0};
        r2sq_next   = {{(SQ_W-RAD2_W){1'b0}}, r2_next} * {{(SQ_W-RAD2_W){1'b0}}, r2_next};
        sw_lim_next = ({1'b0, sw_reg} > MaxDim) ? MaxDim : {1'b0, sw_reg};
        sh_lim_next = ({1'b0, sh_reg} > MaxDim) ? MaxDim : {1'b0, sh_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            top_reg    <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            radius_reg <= '0;
            color_reg  <= '0;
            sw_reg     <= '0;
            sh_reg     <= '0;
            r2_reg     <= '0;
            r2sq_reg   <= '0;
            sw_lim_reg <= '0;
            sh_lim_reg <= '0;
        end
        else
        begin
            r2_reg     <= r2_next;
            r2sq_reg   <= r2sq_next;
            sw_lim_reg <= sw_lim_next;
            sh_lim_reg <= sh_lim_next;
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_RECT_LEFT:     left_reg   <= cfg_data[COORD_W-1:0];
                    CFG_RECT_TOP:      top_reg    <= cfg_data[COORD_W-1:0];
                    CFG_RECT_WIDTH:    width_reg  <= cfg_data[DIM_W-1:0];
                    CFG_RECT_HEIGHT:   height_reg <= cfg_data[DIM_W-1:0];
                    CFG_CORNER_RADIUS: radius_reg <= cfg_data[DIM_W-1:0];
                    CFG_FILL_COLOR:    color_reg  <= cfg_data[PIX_W-1:0];
                    CFG_SCREEN_WIDTH:  sw_reg     <= cfg_data[DIM_W-1:0];
                    CFG_SCREEN_HEIGHT: sh_reg     <= cfg_data[DIM_W-1:0];
                    default:           left_reg   <= left_reg;
                endcase
            end
        end
    end

    always_comb
    begin
        cfg.left   = left_reg;
        cfg.top    = top_reg;
        cfg.w2     = {width_reg, 1'b0};
        cfg.h2     = {height_reg, 1'b0};
        cfg.r2     = r2_reg;
        cfg.r2sq   = r2sq_reg;
        cfg.color  = color_reg;
        cfg.sw_lim = sw_lim_reg;
        cfg.sh_lim = sh_lim_reg;
    end

endmodule

/* design/rraf_coverage.sv */
// ----------------------------------------------------------------------------
// rraf_coverage
// Counts the covered half-pixel samples of one pixel, forms its screen
// position and the on-screen test, and registers the result.
// ----------------------------------------------------------------------------
module rraf_coverage
    import rraf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               in_valid,
    input  logic [LOCAL_W-1:0] col,
    input  logic [LOCAL_W-1:0] row,
    input  logic [PIX_W-1:0]   dst,
    output cov_stage_t         stage
);

    logic [RAD2_W-1:0] fx [2];
    logic [RAD2_W-1:0] fy [2];
    logic              x_in [2];
    logic              y_in [2];
    logic              x_mid [2];
    logic              y_mid [2];
    logic [RAD2_W-1:0] dx [2];
    logic [RAD2_W-1:0] dy [2];
    logic [SQ_W-1:0]   dx_sq [2];
    logic [SQ_W-1:0]   dy_sq [2];
    logic [DIM2_W-1:0] x_hi;
    logic [DIM2_W-1:0] y_hi;
    logic [DIM2_W-1:0] x_diff [2];
    logic [DIM2_W-1:0] y_diff [2];
    logic [SQ_W:0]     dist_sq [4];
    logic [3:0]        hit;
    logic [COV_W-1:0]  cov;
    logic signed [SCR_W-1:0] sx;
    logic signed [SCR_W-1:0] sy;
    logic              on;

    cov_stage_t stage_reg;
    cov_stage_t stage_next;

    always_comb
    begin
        x_hi = cfg.w2 - {1'b0, cfg.r2};
        y_hi = cfg.h2 - {1'b0, cfg.r2};
        for (int i = 0; i < 2; i++)
        begin
            fx[i]     = {col, 1'(i)};
            fy[i]     = {row, 1'(i)};
            x_in[i]   = {1'b0, fx[i]} < cfg.w2;
            y_in[i]   = {1'b0, fy[i]} < cfg.h2;
            x_mid[i]  = (fx[i] >= cfg.r2) && ({1'b0, fx[i]} < x_hi);
            y_mid[i]  = (fy[i] >= cfg.r2) && ({1'b0, fy[i]} < y_hi);
            x_diff[i] = {1'b0, fx[i]} - x_hi;
            y_diff[i] = {1'b0, fy[i]} - y_hi;
            dx[i]     = (fx[i] < cfg.r2) ? (cfg.r2 - fx[i]) : x_diff[i][RAD2_W-1:0];
            dy[i]     = (fy[i] < cfg.r2) ? (cfg.r2 - fy[i]) : y_diff[i][RAD2_W-1:0];
            dx_sq[i]  = {{(SQ_W-RAD2_W){1'b0}}, dx[i]} * {{(SQ_W-RAD2_W){1'b0}}, dx[i]};
            dy_sq[i]  = {{(SQ_W-RAD2_W){1'b0}}, dy[i]} * {{(SQ_W-RAD2_W){1'b0}}, dy[i]};
        end
        cov = '0;
        for (int s = 0; s < 4; s++)
        begin
            dist_sq[s] = {1'b0, dx_sq[s % 2]} + {1'b0, dy_sq[s / 2]};
            hit[s] = x_in[s % 2] && y_in[s / 2] &&
                     (x_mid[s % 2] || y_mid[s / 2] || (dist_sq[s] <= {1'b0, cfg.r2sq}));
            cov = cov + {{(COV_W-1){1'b0}}, hit[s]};
        end

        sx = {cfg.left[COORD_W-1], cfg.left} + $signed({2'b00, col});
        sy = {cfg.top[COORD_W-1], cfg.top} + $signed({2'b00, row});
        on = (cov != '0) && !sx[SCR_W-1] && !sy[SCR_W-1] &&
             (sx[SCR_W-1:0] < cfg.sw_lim) && (sy[SCR_W-1:0] < cfg.sh_lim);

        stage_next.valid = in_valid;
        stage_next.on    = on;
        stage_next.sx    = sx;
        stage_next.sy    = sy;
        stage_next.cov   = cov;
        stage_next.dst   = dst;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage = stage_reg;

endmodule

/* design/rraf_blend.sv */
// ----------------------------------------------------------------------------
// rraf_blend
// Blends the fill color over the stored pixel by coverage and holds the
// result registers of the core.
// ----------------------------------------------------------------------------
module rraf_blend
    import rraf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cov_stage_t              stage,
    input  logic [PIX_W-1:0]        color,
    output logic                    done,
    output logic                    write_enable,
    output logic signed [SCR_W-1:0] screen_x,
    output logic signed [SCR_W-1:0] screen_y,
    output logic [PIX_W-1:0]        new_pixel,
    output logic [COV_W-1:0]        coverage
);

    logic                    done_reg;
    logic                    write_enable_reg;
    logic                    write_enable_next;
    logic signed [SCR_W-1:0] screen_x_reg;
    logic signed [SCR_W-1:0] screen_y_reg;
    logic [PIX_W-1:0]        new_pixel_reg;
    logic [PIX_W-1:0]        new_pixel_next;
    logic [COV_W-1:0]        coverage_reg;

    logic [CH_W-1:0]  alpha;
    logic [CH_W-1:0]  inv_alpha;
    logic [CH_W-1:0]  c_ch [NUM_CH];
    logic [CH_W-1:0]  d_ch [NUM_CH];
    logic [15:0]      mix [NUM_CH];
    logic [CH_W-1:0]  out_ch [NUM_CH];
    logic [PIX_W-1:0] blended;

    always_comb
    begin
        alpha     = alpha_of_cov(stage.cov);
        inv_alpha = ALPHA_OPAQUE - alpha;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            c_ch[ch]   = color[ch*CH_W +: CH_W];
            d_ch[ch]   = stage.dst[ch*CH_W +: CH_W];
            mix[ch]    = ({8'd0, c_ch[ch]} * {8'd0, alpha}) +
                         ({8'd0, d_ch[ch]} * {8'd0, inv_alpha});
            out_ch[ch] = div255(mix[ch]);
        end
        blended = {ALPHA_OPAQUE, out_ch[2], out_ch[1], out_ch[0]};

        write_enable_next = stage.valid && stage.on;
        if (!stage.on)
        begin
            new_pixel_next = '0;
        end
        else if (stage.cov == COV_FULL)
        begin
            new_pixel_next = color;
        end
        else
        begin
            new_pixel_next = blended;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg         <= 1'b0;
            write_enable_reg <= 1'b0;
        end
        else
        begin
            done_reg         <= stage.valid;
            write_enable_reg <= write_enable_next;
        end
    end

    always_ff @(posedge clk)
    begin
        screen_x_reg  <= stage.sx;
        screen_y_reg  <= stage.sy;
        new_pixel_reg <= new_pixel_next;
        coverage_reg  <= stage.cov;
    end

    assign done         = done_reg;
    assign write_enable = write_enable_reg;
    assign screen_x     = screen_x_reg;
    assign screen_y     = screen_y_reg;
    assign new_pixel    = new_pixel_reg;
    assign coverage     = coverage_reg;

endmodule
